// ----- hw/rtl/sss_pkg.sv -----
package sss_pkg;

  localparam int STEP_BITS_DEF = 16;

  localparam logic [11:0] PULSE_MIN    = 12'd500;
  localparam logic [11:0] PULSE_MAX    = 12'd2500;
  localparam logic [11:0] PULSE_CENTER = 12'd1500;
  localparam logic [7:0]  SAFE_MIN_DEG = 8'd5;
  localparam logic [7:0]  SAFE_MAX_DEG = 8'd175;
  localparam logic [7:0]  DEG_MAX      = 8'd180;
  localparam logic [15:0] Q15_ONE      = 16'd32768;
  localparam logic [15:0] Q15_HALF     = 16'd16384;
  localparam logic [15:0] DUR_MIN      = 16'd5;
  localparam logic [15:0] TICK_MIN     = 16'd2;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_MOVE  = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  origin_deg;
    logic [7:0]  end_deg;
    logic [15:0] sweep_ms;
    logic [15:0] tick_ms;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pulse_us;
    logic [7:0]  angle_deg;
    logic        done_res;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_CHECK, S_STEPS, S_STEPS_W, S_START,
    S_TDIV, S_TDIV_W, S_CAPT, S_M2, S_M3, S_M4, S_M5, S_POLY, S_ANG,
    S_PMAP, S_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_DEC, OP_DIV_STEPS, OP_START,
    OP_DIV_T, OP_CAP_T, OP_M2, OP_M3, OP_M4, OP_M5, OP_POLY, OP_ANG,
    OP_PMAP, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       div_done;
    logic       cur_eq;
    logic       out_busy;
  } stat_t;

endpackage

// ----- hw/rtl/sss_div.sv -----
module sss_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [W-1:0] quo,
  output logic         done
);

  localparam int CW = $clog2(W);

  logic [W-1:0]  rem_r, quo_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [W:0]    trial;
  logic          ge;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem_r, quo_r[W-1]} - {1'b0, den_r};
  assign ge    = ~trial[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? trial[W-1:0] : {rem_r[W-2:0], quo_r[W-1]};
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ----- hw/rtl/sss_ctrl.sv -----
module sss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sss_pkg::stat_t stat,
  output sss_pkg::cmd_t  cmd
);

  sss_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sss_pkg::S_IDLE: begin
        if (in_valid) begin
          case (stat.mode)
            sss_pkg::MODE_START: state_nxt = sss_pkg::S_STEPS;
            sss_pkg::MODE_TICK:  state_nxt = sss_pkg::S_TDIV;
            sss_pkg::MODE_MOVE:  state_nxt = sss_pkg::S_DEC;
            default:             state_nxt = sss_pkg::S_IDLE;
          endcase
        end
      end
      sss_pkg::S_DEC:     state_nxt = sss_pkg::S_CHECK;
      sss_pkg::S_CHECK:   state_nxt = stat.cur_eq ? sss_pkg::S_IDLE : sss_pkg::S_STEPS;
      sss_pkg::S_STEPS:   state_nxt = sss_pkg::S_STEPS_W;
      sss_pkg::S_STEPS_W: if (stat.div_done) state_nxt = sss_pkg::S_START;
      sss_pkg::S_START:   state_nxt = sss_pkg::S_TDIV;
      sss_pkg::S_TDIV:    state_nxt = sss_pkg::S_TDIV_W;
      sss_pkg::S_TDIV_W:  if (stat.div_done) state_nxt = sss_pkg::S_CAPT;
      sss_pkg::S_CAPT:    state_nxt = sss_pkg::S_M2;
      sss_pkg::S_M2:      state_nxt = sss_pkg::S_M3;
      sss_pkg::S_M3:      state_nxt = sss_pkg::S_M4;
      sss_pkg::S_M4:      state_nxt = sss_pkg::S_M5;
      sss_pkg::S_M5:      state_nxt = sss_pkg::S_POLY;
      sss_pkg::S_POLY:    state_nxt = sss_pkg::S_ANG;
      sss_pkg::S_ANG:     state_nxt = sss_pkg::S_PMAP;
      sss_pkg::S_PMAP:    state_nxt = sss_pkg::S_OUT;
      sss_pkg::S_OUT:     if (!stat.out_busy) state_nxt = sss_pkg::S_IDLE;
      default:            state_nxt = sss_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = sss_pkg::OP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      sss_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = sss_pkg::OP_LOAD;
      end
      sss_pkg::S_DEC:   cmd.op = sss_pkg::OP_DEC;
      sss_pkg::S_STEPS: cmd.op = sss_pkg::OP_DIV_STEPS;
      sss_pkg::S_START: cmd.op = sss_pkg::OP_START;
      sss_pkg::S_TDIV:  cmd.op = sss_pkg::OP_DIV_T;
      sss_pkg::S_CAPT:  cmd.op = sss_pkg::OP_CAP_T;
      sss_pkg::S_M2:    cmd.op = sss_pkg::OP_M2;
      sss_pkg::S_M3:    cmd.op = sss_pkg::OP_M3;
      sss_pkg::S_M4:    cmd.op = sss_pkg::OP_M4;
      sss_pkg::S_M5:    cmd.op = sss_pkg::OP_M5;
      sss_pkg::S_POLY:  cmd.op = sss_pkg::OP_POLY;
      sss_pkg::S_ANG:   cmd.op = sss_pkg::OP_ANG;
      sss_pkg::S_PMAP:  cmd.op = sss_pkg::OP_PMAP;
      sss_pkg::S_OUT:   if (!stat.out_busy) cmd.op = sss_pkg::OP_EMIT;
      default:          cmd.op = sss_pkg::OP_NONE;
    endcase
  end

endmodule

// ----- hw/rtl/sss_dpath.sv -----
module sss_dpath #(
  parameter int STEP_BITS = sss_pkg::STEP_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sss_pkg::in_item_t  in_data,
  input  sss_pkg::cmd_t      cmd,
  output sss_pkg::stat_t     stat,
  output logic               out_valid,
  input  logic               out_ready,
  output sss_pkg::out_item_t out_data
);

  localparam int DW = STEP_BITS + 16;
  localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};

  // Reciprocal multiplies: floor(y * 94374 / 2^20) equals floor(y * 9 / 100) for y up to
  // 2000, and floor(d * 1456400 / 2^17) equals floor(d * 100 / 9) for d up to 175.
  localparam logic [27:0] DEC_RECIP  = 28'd94374;
  localparam logic [28:0] PMAP_RECIP = 29'd1456400;

  logic [7:0]           ed_r, from_r;
  logic [15:0]          dur_r, tick_r;
  logic [7:0]           sweep_start_r, sweep_end_r;
  logic [STEP_BITS-1:0] step_total_r, step_index_r;
  logic [11:0]          pulse_width_r, pulse_q_r;
  logic [15:0]          t_r, t2_r, t3_r, t4_r, t5_r, s_r;
  logic [7:0]           angle_r;
  logic                 done_r;
  logic                 out_valid_r;
  sss_pkg::out_item_t   out_r;

  logic          div_start, div_done;
  logic [DW-1:0] div_num, div_den, div_quo;

  sss_div #(.W(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // Clamped input angles.
  logic [7:0] sd_c, ed_c;
  assign sd_c = (in_data.origin_deg > sss_pkg::DEG_MAX) ? sss_pkg::DEG_MAX :
                in_data.origin_deg;
  assign ed_c = (in_data.end_deg > sss_pkg::DEG_MAX) ? sss_pkg::DEG_MAX : in_data.end_deg;

  // Sample index clamped to the step count.
  logic [STEP_BITS-1:0] n_eff, k_eff;
  assign n_eff = (step_total_r == '0) ? STEP_BITS'(1) : step_total_r;
  assign k_eff = (step_index_r > n_eff) ? n_eff : step_index_r;

  // Angle decoded from the held pulse.
  logic [11:0] us_c, dec_ofs;
  logic [27:0] dec_prod;
  assign us_c = (pulse_width_r < sss_pkg::PULSE_MIN) ? sss_pkg::PULSE_MIN :
                (pulse_width_r > sss_pkg::PULSE_MAX) ? sss_pkg::PULSE_MAX : pulse_width_r;
  assign dec_ofs  = us_c - sss_pkg::PULSE_MIN;
  assign dec_prod = 28'(dec_ofs) * DEC_RECIP;

  logic [15:0] dur_c, tick_c;
  assign dur_c  = (dur_r < sss_pkg::DUR_MIN) ? sss_pkg::DUR_MIN : dur_r;
  assign tick_c = (tick_r < sss_pkg::TICK_MIN) ? sss_pkg::TICK_MIN : tick_r;

  // Pulse mapping of the sample angle.
  logic [7:0]  deg_c;
  logic [28:0] p_prod;
  assign deg_c = (angle_r < sss_pkg::SAFE_MIN_DEG) ? sss_pkg::SAFE_MIN_DEG :
                 (angle_r > sss_pkg::SAFE_MAX_DEG) ? sss_pkg::SAFE_MAX_DEG : angle_r;
  assign p_prod = 29'(deg_c) * PMAP_RECIP;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      sss_pkg::OP_DIV_STEPS: begin
        div_start = 1'b1;
        div_num   = DW'(dur_c);
        div_den   = DW'(tick_c);
      end
      sss_pkg::OP_DIV_T: begin
        div_start = 1'b1;
        div_num   = DW'({k_eff, 15'd0});
        div_den   = DW'(step_total_r);
      end
      default: ;
    endcase
  end

  // Saturated step count.
  logic [STEP_BITS-1:0] steps;
  always_comb begin
    if (div_quo == '0) begin
      steps = STEP_BITS'(1);
    end else if (div_quo > DW'(STEP_MAX)) begin
      steps = STEP_MAX;
    end else begin
      steps = div_quo[STEP_BITS-1:0];
    end
  end

  // Shared Q15 multiplier with rounding.
  logic [15:0] mul_a, qm;
  logic [32:0] mul_sum;
  always_comb begin
    case (cmd.op)
      sss_pkg::OP_M3: mul_a = t2_r;
      sss_pkg::OP_M4: mul_a = t3_r;
      sss_pkg::OP_M5: mul_a = t4_r;
      default:        mul_a = t_r;
    endcase
  end
  assign mul_sum = 33'(mul_a * t_r) + 33'(sss_pkg::Q15_HALF);
  assign qm      = mul_sum[30:15];

  // Quintic smoothstep polynomial, clamped to 0..1.
  logic signed [21:0] poly;
  logic [15:0]        s_c;
  assign poly = $signed(22'(t5_r) * 22'd6) - $signed(22'(t4_r) * 22'd15)
              + $signed(22'(t3_r) * 22'd10);
  assign s_c  = (poly < 0) ? 16'd0 :
                (poly > $signed(22'(sss_pkg::Q15_ONE))) ? sss_pkg::Q15_ONE : poly[15:0];

  // Interpolated angle: start + round(diff * s).
  logic signed [8:0]  diff;
  logic signed [26:0] prod;
  logic signed [27:0] rsum;
  logic signed [12:0] a_full;
  logic [7:0]         a_c;
  assign diff   = $signed({1'b0, sweep_end_r}) - $signed({1'b0, sweep_start_r});
  assign prod   = 27'(diff) * $signed({11'd0, s_r});
  assign rsum   = 28'(prod) + $signed(28'(sss_pkg::Q15_HALF));
  assign a_full = $signed({5'd0, sweep_start_r}) + 13'(rsum >>> 15);
  assign a_c    = (a_full < 0) ? 8'd0 :
                  (a_full > $signed(13'(sss_pkg::DEG_MAX))) ? sss_pkg::DEG_MAX : a_full[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_start_r <= '0;
      sweep_end_r   <= '0;
      step_total_r  <= STEP_BITS'(1);
      step_index_r  <= '0;
      pulse_width_r <= sss_pkg::PULSE_CENTER;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.op == sss_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        sss_pkg::OP_START: begin
          sweep_start_r <= from_r;
          sweep_end_r   <= ed_r;
          step_total_r  <= steps;
          step_index_r  <= '0;
        end
        sss_pkg::OP_ANG: begin
          step_index_r <= (k_eff < n_eff) ? k_eff + 1'b1 : n_eff;
        end
        sss_pkg::OP_EMIT: begin
          pulse_width_r <= pulse_q_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      sss_pkg::OP_LOAD: begin
        ed_r   <= ed_c;
        from_r <= sd_c;
        dur_r  <= in_data.sweep_ms;
        tick_r <= in_data.tick_ms;
      end
      sss_pkg::OP_DEC:   from_r <= dec_prod[27:20];
      sss_pkg::OP_CAP_T: t_r    <= div_quo[15:0];
      sss_pkg::OP_M2:    t2_r   <= qm;
      sss_pkg::OP_M3:    t3_r   <= qm;
      sss_pkg::OP_M4:    t4_r   <= qm;
      sss_pkg::OP_M5:    t5_r   <= qm;
      sss_pkg::OP_POLY:  s_r    <= s_c;
      sss_pkg::OP_ANG: begin
        angle_r <= a_c;
        done_r  <= (k_eff == n_eff);
      end
      sss_pkg::OP_PMAP:  pulse_q_r <= sss_pkg::PULSE_MIN + p_prod[28:17];
      sss_pkg::OP_EMIT: begin
        out_r.pulse_us  <= pulse_q_r;
        out_r.angle_deg <= angle_r;
        out_r.done_res  <= done_r;
      end
      default: ;
    endcase
  end

  assign stat.mode     = in_data.mode;
  assign stat.div_done = div_done;
  assign stat.cur_eq   = (from_r == ed_r);
  assign stat.out_busy = out_valid_r & ~out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- hw/rtl/servo_scurve_sweep_top.sv -----
// Servo S-curve sweep generator. Each accepted item either starts a sweep (mode 0 from
// origin_deg, mode 2 from the angle held in the last pulse) or advances one tick (mode 1),
// and gives at most one sample: pulse width, clamped angle and a done flag on the last
// step. Mode 2 toward the angle it already holds, and mode 3, give no result. Items are
// handled one at a time. The step count and the sweep fraction go through one restoring
// divider of STEP_BITS+16 bits that yields one quotient bit per cycle; the pulse mapping
// and decoding use reciprocal multiplies. A result waiting in the output register does
// not block the next item from being accepted; that item's result waits until the one
// before it has been taken.
module servo_scurve_sweep_top #(
  parameter int STEP_BITS = sss_pkg::STEP_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sss_pkg::out_item_t out_data
);

  sss_pkg::cmd_t  cmd;
  sss_pkg::stat_t stat;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sss_dpath #(.STEP_BITS(STEP_BITS)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pulse_us >= sss_pkg::PULSE_MIN &&
                   out_data.pulse_us <= sss_pkg::PULSE_MAX))
    else $error("pulse out of range");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.angle_deg <= sss_pkg::DEG_MAX))
    else $error("angle out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.mode != sss_pkg::MODE_RSVD) |=> !in_ready)
    else $error("item accepted while busy");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == sss_pkg::OP_EMIT) |-> (!out_valid || out_ready))
    else $error("result overwrote a pending item");

endmodule

// ----- bench/servo_scurve_sweep_top_tb.sv -----
module servo_scurve_sweep_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  sss_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  sss_pkg::out_item_t out_data;

  servo_scurve_sweep_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Predicted trajectory state.
  logic [7:0]  traj_from;
  logic [7:0]  traj_to;
  logic [15:0] traj_steps;
  logic [15:0] traj_next;
  logic [11:0] traj_pulse;

  sss_pkg::out_item_t samples_due[$];
  int errors;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("servo_scurve_sweep_top verification failed");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint unsigned q15_mul(longint unsigned a, longint unsigned b);
    return (a * b + 16384) >> 15;
  endfunction

  function automatic logic [11:0] deg_to_pulse(longint a);
    if (a < sss_pkg::SAFE_MIN_DEG) a = sss_pkg::SAFE_MIN_DEG;
    if (a > sss_pkg::SAFE_MAX_DEG) a = sss_pkg::SAFE_MAX_DEG;
    return 12'(500 + (2000 * a) / 180);
  endfunction

  function automatic sss_pkg::out_item_t next_sample();
    longint unsigned k, n, t, t2, t3, t4, t5;
    longint s, a;
    sss_pkg::out_item_t r;
    k = traj_next;
    n = traj_steps;
    if (n == 0) n = 1;
    if (k > n) k = n;
    t = (32768 * k) / n;
    t2 = q15_mul(t, t);
    t3 = q15_mul(t2, t);
    t4 = q15_mul(t3, t);
    t5 = q15_mul(t4, t);
    s = 6 * longint'(t5) - 15 * longint'(t4) + 10 * longint'(t3);
    if (s < 0) s = 0;
    if (s > 32768) s = 32768;
    a = (longint'(traj_to) - longint'(traj_from)) * s + 16384 + 180 * 32768;
    a = longint'(traj_from) + ((a >>> 15) - 180);
    if (a < 0) a = 0;
    if (a > 180) a = 180;
    traj_pulse = deg_to_pulse(a);
    r.pulse_us = traj_pulse;
    r.angle_deg = 8'(a);
    r.done_res = (k == n);
    traj_next = (k < n) ? 16'(k + 1) : 16'(n);
    return r;
  endfunction

  function automatic void begin_sweep(logic [7:0] from, logic [7:0] to,
                                      logic [15:0] dur, logic [15:0] tick);
    int unsigned d, tk, st;
    d = (dur < 5) ? 5 : dur;
    tk = (tick < 2) ? 2 : tick;
    st = d / tk;
    if (st < 1) st = 1;
    traj_from = from;
    traj_to = to;
    traj_steps = 16'(st);
    traj_next = 0;
    samples_due.push_back(next_sample());
  endfunction

  function automatic void predict_item(sss_pkg::in_item_t it);
    logic [7:0] sd, ed, cur;
    int unsigned p;
    sd = (it.origin_deg > 180) ? 8'd180 : it.origin_deg;
    ed = (it.end_deg > 180) ? 8'd180 : it.end_deg;
    case (it.mode)
      sss_pkg::MODE_START: begin
        begin_sweep(sd, ed, it.sweep_ms, it.tick_ms);
      end
      sss_pkg::MODE_TICK: begin
        samples_due.push_back(next_sample());
      end
      sss_pkg::MODE_MOVE: begin
        p = traj_pulse;
        if (p < 500) p = 500;
        if (p > 2500) p = 2500;
        cur = 8'(((p - 500) * 180) / 2000);
        if (cur != ed) begin_sweep(cur, ed, it.sweep_ms, it.tick_ms);
      end
      default: ;
    endcase
  endfunction

  // Result side: random stalls and checking.
  initial begin
    int w;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
      if (samples_due.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        sss_pkg::out_item_t e;
        e = samples_due.pop_front();
        if (out_data.pulse_us !== e.pulse_us) report("pulse_us", out_data.pulse_us, e.pulse_us);
        if (out_data.angle_deg !== e.angle_deg)
          report("angle_deg", out_data.angle_deg, e.angle_deg);
        if (out_data.done_res !== e.done_res) report("done_res", out_data.done_res, e.done_res);
      end
    end
  end

  bit sender_busy_gaps = 1'b1;

  task automatic send_item(logic [1:0] mode, logic [7:0] sd, logic [7:0] ed,
                           logic [15:0] dur, logic [15:0] tick);
    sss_pkg::in_item_t it;
    int w;
    it.mode = mode;
    it.origin_deg = sd;
    it.end_deg = ed;
    it.sweep_ms = dur;
    it.tick_ms = tick;
    w = sender_busy_gaps ? $urandom_range(0, 9) : 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk iff in_ready);
    predict_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(sss_pkg::MODE_TICK, 0, 0, 0, 0);    // tick on the reset state
    send_item(sss_pkg::MODE_MOVE, 0, 4, 10, 2);   // already at the held angle: no result
    send_item(sss_pkg::MODE_START, 0, 180, 0, 0); // duration and tick raised
    send_item(sss_pkg::MODE_TICK, 0, 0, 0, 0);
    send_item(sss_pkg::MODE_TICK, 0, 0, 0, 0);
    send_item(sss_pkg::MODE_START, 255, 255, 65535, 65535);
    send_item(sss_pkg::MODE_START, 180, 0, 65535, 0);  // largest step count
    repeat (3) send_item(sss_pkg::MODE_TICK, 0, 0, 0, 0);
    send_item(sss_pkg::MODE_START, 3, 178, 20, 3);
    repeat (8) send_item(sss_pkg::MODE_TICK, 0, 0, 0, 0); // runs past the end
    send_item(sss_pkg::MODE_MOVE, 0, 0, 12, 4);
    send_item(sss_pkg::MODE_MOVE, 0, 200, 9, 2);
    send_item(sss_pkg::MODE_RSVD, 8'hff, 8'hff, 16'hffff, 16'hffff);
    send_item(sss_pkg::MODE_MOVE, 0, 175, 9, 2);
    drain();
  endtask

  task automatic test_random_sweeps(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      int r, ticks;
      r = $urandom_range(0, 9);
      if (r < 7) begin
        send_item((r < 4) ? sss_pkg::MODE_START : sss_pkg::MODE_MOVE, 8'($urandom),
                  8'($urandom), 16'($urandom_range(0, 60)), 16'($urandom_range(0, 12)));
        ticks = $urandom_range(1, 14);
        repeat (ticks) send_item(sss_pkg::MODE_TICK, 8'($urandom), 8'($urandom),
                                 16'($urandom), 16'($urandom));
        sent += ticks + 1;
      end else begin
        send_item(2'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_burst_after_drain();
    sender_busy_gaps = 1'b0;
    send_item(sss_pkg::MODE_START, 10, 170, 40, 2);
    repeat (25) send_item(sss_pkg::MODE_TICK, 0, 0, 0, 0);
    sender_busy_gaps = 1'b1;
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    errors = 0;
    cycles = 0;
    traj_from = 0;
    traj_to = 0;
    traj_steps = 1;
    traj_next = 0;
    traj_pulse = sss_pkg::PULSE_CENTER;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_sweeps(220);
    drain();
    test_burst_after_drain();
    test_random_sweeps(200);
    drain();
    if (errors == 0) begin
      $display("servo_scurve_sweep_top verification clean");
    end else begin
      $display("servo_scurve_sweep_top verification failed");
    end
    $finish;
  end

endmodule

// ----- servo_scurve_sweep_top.f -----
hw/rtl/sss_pkg.sv
hw/rtl/sss_div.sv
hw/rtl/sss_ctrl.sv
hw/rtl/sss_dpath.sv
hw/rtl/servo_scurve_sweep_top.sv
bench/servo_scurve_sweep_top_tb.sv
